>>> design/wdmm_pkg.sv
// ----------------------------------------------------------------------------
// Window min/mean/max shared definitions
// Sample type, sample width and the sequencer states of the window core.
// ----------------------------------------------------------------------------
package wdmm_pkg;

	localparam int SAMPLE_W = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

>>> design/wdmm_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// One entry of the sample ring; takes its neighbor's value on every shift.
// ----------------------------------------------------------------------------
module wdmm_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  wdmm_pkg::sample_t din,
	output wdmm_pkg::sample_t value
);

	wdmm_pkg::sample_t value_q;

	// Entries that were never written must read as zero, so the cell resets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift) begin
			value_q <= din;
		end
	end

	assign value = value_q;

endmodule

>>> design/wdmm_mean.sv
// ----------------------------------------------------------------------------
// Window mean
// Floored division of the window sum by the depth through a reciprocal
// multiply, with one register after the product.
// ----------------------------------------------------------------------------
module wdmm_mean #(
	parameter int DEPTH = 8,
	parameter int SUM_W = 19
) (
	input  logic                    clk,
	input  logic signed [SUM_W-1:0] sum,
	output wdmm_pkg::sample_t       mean
);

	localparam int L_W   = $clog2(DEPTH);
	localparam int SHIFT = SUM_W + L_W;
	localparam int M_W   = SUM_W + 2;
	localparam int P_W   = SUM_W + M_W;
	localparam logic [M_W-1:0] RECIP =
		M_W'(((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
	localparam logic [SUM_W-1:0] OFFSET = SUM_W'(DEPTH * 32768);

	logic [SUM_W-1:0] biased;
	logic [P_W-1:0]   product_s1;
	logic [15:0]      quot;

	// Biasing by DEPTH*32768 makes the dividend non-negative; the quotient
	// then carries a bias of 32768, removed by flipping its top bit.
	assign biased = unsigned'(sum) + OFFSET;

	always_ff @(posedge clk) begin
		product_s1 <= P_W'(biased) * P_W'(RECIP);
	end

	assign quot = product_s1[SHIFT +: 16];
	assign mean = {~quot[15], quot[14:0]};

endmodule

>>> design/window_min_mean_max_core.sv
// ----------------------------------------------------------------------------
// Window min/mean/max core
// Sliding window of distance samples; reports minimum, maximum and floored
// mean over the whole window after every sample.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   input   | in        | in_valid / in_stall  | sample
//   output  | out       | out_valid / out_stall| window_min, window_max,
//           |           |                      | window_mean
//
// A word passes through these steps in order: the accept cycle shifts the
// sample into the ring of cells, the scan rotates the ring once past the
// min/max tracker, and the emit step loads the output register once it is
// free. The next word can be accepted in the cycle after that load; the core
// takes no new sample while it is busy with a word. The ring rotation sets
// the rate while the output is not stalled.
// Reset clears every cell, the running sum and the control state, so unused
// entries count as zero. A stalled result sits in the output register while
// the next word is already accepted and scanned.
// ----------------------------------------------------------------------------
module window_min_mean_max_core #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  wdmm_pkg::sample_t sample,
	output logic              out_valid,
	input  logic              out_stall,
	output wdmm_pkg::sample_t window_min,
	output wdmm_pkg::sample_t window_max,
	output wdmm_pkg::sample_t window_mean
);

	localparam int SUM_W = wdmm_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH);

	wdmm_pkg::state_t state_q, state_d;

	logic              shift_en;
	logic              load_sample;
	logic              load_out;
	wdmm_pkg::sample_t head_din;
	wdmm_pkg::sample_t cell_val [WINDOW_DEPTH];
	wdmm_pkg::sample_t tail;

	logic [CNT_W-1:0]        cnt_q;
	logic                    scan_last;
	logic signed [SUM_W-1:0] sum_q;
	wdmm_pkg::sample_t       min_q, max_q;
	wdmm_pkg::sample_t       mean_val;
	logic                    out_valid_q;
	wdmm_pkg::sample_t       min_out_q, max_out_q, mean_out_q;

	// The ring of cells. Cell zero is the head; the tail holds the oldest
	// sample. A new sample enters at the head and pushes the oldest out;
	// during the scan the tail wraps back to the head, so after WINDOW_DEPTH
	// rotations the ring is back in its original order.
	assign tail     = cell_val[WINDOW_DEPTH-1];
	assign head_din = load_sample ? sample : tail;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			wdmm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift_en),
				.din    (head_din),
				.value  (cell_val[i])
			);
		end else begin : g_body
			wdmm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift_en),
				.din    (cell_val[i-1]),
				.value  (cell_val[i])
			);
		end
	end

	assign scan_last = (cnt_q == CNT_W'(WINDOW_DEPTH - 1));

	// Sequencer: accept a word, rotate the ring once, then hand the result
	// to the output register as soon as it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wdmm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		shift_en    = 1'b0;
		load_sample = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			wdmm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					shift_en    = 1'b1;
					load_sample = 1'b1;
					state_d     = wdmm_pkg::ST_SCAN;
				end
			end
			wdmm_pkg::ST_SCAN: begin
				shift_en = 1'b1;
				if (scan_last) begin
					state_d = wdmm_pkg::ST_EMIT;
				end
			end
			wdmm_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = wdmm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wdmm_pkg::ST_IDLE;
			end
		endcase
	end

	// Scan counter and running sum. The sum drops the outgoing tail entry
	// and adds the new sample in the accept cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else begin
			if (load_sample) begin
				cnt_q <= '0;
				sum_q <= sum_q - SUM_W'(tail) + SUM_W'(sample);
			end else if (state_q == wdmm_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Min/max tracker: sees one entry per scan cycle at the tail.
	always_ff @(posedge clk) begin
		if (state_q == wdmm_pkg::ST_SCAN) begin
			if (cnt_q == '0) begin
				min_q <= tail;
				max_q <= tail;
			end else begin
				if (tail < min_q) begin
					min_q <= tail;
				end
				if (tail > max_q) begin
					max_q <= tail;
				end
			end
		end
	end

	// Mean: the product register settles during the scan.
	wdmm_mean #(
		.DEPTH (WINDOW_DEPTH),
		.SUM_W (SUM_W)
	) u_mean (
		.clk  (clk),
		.sum  (sum_q),
		.mean (mean_val)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			min_out_q  <= min_q;
			max_out_q  <= max_q;
			mean_out_q <= mean_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_min  = min_out_q;
	assign window_max  = max_out_q;
	assign window_mean = mean_out_q;

endmodule
